/* design/bc_texture_block_decoder_unit_macros.svh */
// Assertion macros for the texture block decoder.
`ifndef BC_TEXTURE_BLOCK_DECODER_UNIT_MACROS_SVH
`define BC_TEXTURE_BLOCK_DECODER_UNIT_MACROS_SVH

// same-cycle implication
`define BCTD_ASSERT_IMPL(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("bctd: same-cycle check failed");

// next-cycle implication
`define BCTD_ASSERT_NEXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("bctd: next-cycle check failed");

`endif

/* design/bctd_pkg.sv */
// Types and constants shared by the texture block decoder modules.
package bctd_pkg;

	localparam int DIM_W       = 15;
	localparam int COUNT_W     = 12;
	localparam int COORD_W     = 14;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 15;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	typedef enum logic [1:0] {
		FMT_BC1 = 2'd0,
		FMT_BC2 = 2'd1,
		FMT_BC3 = 2'd2
	} fmt_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} rgba_t;

	typedef struct packed {
		fmt_t                  fmt;
		rgba_t [3:0]           pal;
		logic [7:0][7:0]       atab;
		logic [15:0][1:0]      cidx;
		logic [15:0][3:0]      anib;
		logic [15:0][2:0]      aidx;
		logic [15:0]           mask;
		logic [COUNT_W-1:0]    bx;
		logic [COUNT_W-1:0]    by;
		logic                  last_block;
	} blk_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

/* design/bctd_ifs.sv */
// Handshake interfaces for compressed blocks and decoded pixels.
interface bctd_block_if;
	logic        valid;
	logic        ready;
	logic [63:0] color_part;
	logic [63:0] alpha_part;

	modport source(output valid, color_part, alpha_part, input ready);
	modport sink(input valid, color_part, alpha_part, output ready);
endinterface

interface bctd_pixel_if;
	logic        valid;
	logic        ready;
	logic [13:0] pixel_x;
	logic [13:0] pixel_y;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic        block_done;
	logic        image_done;

	modport source(output valid, pixel_x, pixel_y, red, green, blue, alpha, block_done,
		image_done, input ready);
	modport sink(input valid, pixel_x, pixel_y, red, green, blue, alpha, block_done,
		image_done, output ready);
endinterface

/* design/bc_texture_block_decoder_unit.sv */
// Top level of the BC1/BC2/BC3 texture block decoder.
// Path: an accepted block is registered in the front end, queued, loaded into the
// back end, and each of its pixels is registered at the output. While a block is
// emitted, the front end and a two-entry queue take further blocks. The back end
// pixel counter steps one position per cycle; only emitted ones wait on a stall.
// Reset: arst_n clears the position to block 0,0 and sets BC1, 4x4 pixels.
`include "bc_texture_block_decoder_unit_macros.svh"

module bc_texture_block_decoder_unit #(
	parameter int MAX_DIMENSION = 16384
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bctd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bctd_pkg::CFG_DATA_W-1:0] cfg_data,
	bctd_block_if.sink                      blk,
	bctd_pixel_if.source                    pix
);
	import bctd_pkg::*;

	logic       push;
	logic       pop;
	blk_entry_t push_data;
	blk_entry_t pop_data;
	qstat_t     qstat;

	bctd_front #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.blk       (blk),
		.push      (push),
		.push_data (push_data),
		.qstat     (qstat)
	);

	bctd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	bctd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_data (pop_data),
		.pop      (pop),
		.pix      (pix)
	);

	`BCTD_ASSERT_IMPL(a_image_done_ends_block, clk, arst_n, pix.valid && pix.image_done, pix.block_done)
	`BCTD_ASSERT_IMPL(a_no_push_when_full, clk, arst_n, push, !qstat.full)
	`BCTD_ASSERT_IMPL(a_no_pop_when_empty, clk, arst_n, pop, !qstat.empty)
	`BCTD_ASSERT_NEXT(a_push_fills_queue, clk, arst_n, push && !pop, !qstat.empty)

endmodule

/* design/bctd_front.sv */
// Front end: configuration, block position, palette and alpha table build.
module bctd_front #(
	parameter int MAX_DIMENSION = 16384
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bctd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bctd_pkg::CFG_DATA_W-1:0] cfg_data,
	bctd_block_if.sink                     blk,
	output logic                           push,
	output bctd_pkg::blk_entry_t           push_data,
	input  bctd_pkg::qstat_t               qstat
);
	import bctd_pkg::*;

	localparam int LIM = (MAX_DIMENSION < 16384) ? MAX_DIMENSION : 16384;
	localparam logic [DIM_W-1:0] DIM_LIM = DIM_W'(LIM);
	localparam int BC_W = DIM_W - 1;

	typedef struct packed {
		fmt_t                  fmt;
		logic                  three;
		logic [2:0][7:0]       e0;
		logic [2:0][7:0]       e1;
		logic [2:0][9:0]       n2;
		logic [2:0][9:0]       n3;
		logic                  agt;
		logic [7:0]            a0;
		logic [7:0]            a1;
		logic [5:0][10:0]      an;
		logic [15:0][1:0]      cidx;
		logic [63:0]           apart;
		logic [15:0]           mask;
		logic [COUNT_W-1:0]    bx;
		logic [COUNT_W-1:0]    by;
		logic                  last_block;
	} s1_t;

	function automatic logic [2:0][7:0] widen565(input logic [15:0] v);
		return {v[15:11], v[15:13], v[10:5], v[10:9], v[4:0], v[4:2]};
	endfunction

	function automatic logic [7:0] div3(input logic [9:0] n);
		logic [19:0] prod;
		prod = 20'(n) * 20'd683;
		return prod[18:11];
	endfunction

	function automatic logic [7:0] div7(input logic [10:0] n);
		logic [23:0] prod;
		prod = 24'(n) * 24'd4682;
		return prod[22:15];
	endfunction

	function automatic logic [7:0] div5(input logic [10:0] n);
		logic [23:0] prod;
		prod = 24'(n) * 24'd6554;
		return prod[22:15];
	endfunction

	logic [1:0]         fmt_raw_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [COUNT_W-1:0] col_q;
	logic [COUNT_W-1:0] row_q;
	logic               s1_valid_s1;
	s1_t                s1_s1;

	logic [DIM_W-1:0]   w_c;
	logic [DIM_W-1:0]   h_c;
	logic [DIM_W:0]     w_sum;
	logic [DIM_W:0]     h_sum;
	logic [BC_W-1:0]    bx_cnt;
	logic [BC_W-1:0]    by_cnt;
	logic [BC_W-1:0]    col_nx;
	logic [BC_W-1:0]    row_nx;
	logic [3:0]         col_ok;
	logic [3:0]         row_ok;
	fmt_t               fmt_c;
	logic               acc;
	s1_t                s1_d;
	logic [2:0][7:0]    c2;
	logic [2:0][7:0]    c3;

	always_comb begin
		w_c = (width_q == '0) ? DIM_W'(1) : ((width_q > DIM_LIM) ? DIM_LIM : width_q);
		h_c = (height_q == '0) ? DIM_W'(1) : ((height_q > DIM_LIM) ? DIM_LIM : height_q);
		w_sum = {1'b0, w_c} + (DIM_W+1)'(3);
		h_sum = {1'b0, h_c} + (DIM_W+1)'(3);
		bx_cnt = w_sum[DIM_W:2];
		by_cnt = h_sum[DIM_W:2];
		col_nx = BC_W'(col_q) + BC_W'(1);
		row_nx = BC_W'(row_q) + BC_W'(1);
		for (int c = 0; c < 4; c++) begin
			col_ok[c] = {1'b0, col_q, 2'(c)} < w_c;
			row_ok[c] = {1'b0, row_q, 2'(c)} < h_c;
		end
		case (fmt_raw_q)
			FMT_BC2: fmt_c = FMT_BC2;
			FMT_BC3: fmt_c = FMT_BC3;
			default: fmt_c = FMT_BC1;
		endcase
	end

	assign blk.ready = !s1_valid_s1 || !qstat.full;
	assign acc       = blk.valid && blk.ready;
	assign push      = s1_valid_s1 && !qstat.full;

	always_comb begin
		s1_d.fmt   = fmt_c;
		s1_d.e0    = widen565(blk.color_part[15:0]);
		s1_d.e1    = widen565(blk.color_part[31:16]);
		s1_d.three = (fmt_c == FMT_BC1) && (blk.color_part[15:0] <= blk.color_part[31:16]);
		for (int ch = 0; ch < 3; ch++) begin
			s1_d.n2[ch] = s1_d.three ? ({2'b00, s1_d.e0[ch]} + {2'b00, s1_d.e1[ch]})
				: ({1'b0, s1_d.e0[ch], 1'b0} + {2'b00, s1_d.e1[ch]});
			s1_d.n3[ch] = {2'b00, s1_d.e0[ch]} + {1'b0, s1_d.e1[ch], 1'b0};
		end
		s1_d.a0  = blk.alpha_part[7:0];
		s1_d.a1  = blk.alpha_part[15:8];
		s1_d.agt = s1_d.a0 > s1_d.a1;
		for (int i = 1; i <= 6; i++) begin
			if (s1_d.agt) begin
				s1_d.an[i-1] = 11'(7 - i) * 11'(s1_d.a0) + 11'(i) * 11'(s1_d.a1);
			end else if (i <= 4) begin
				s1_d.an[i-1] = 11'(5 - i) * 11'(s1_d.a0) + 11'(i) * 11'(s1_d.a1);
			end else begin
				s1_d.an[i-1] = '0;
			end
		end
		s1_d.cidx  = blk.color_part[63:32];
		s1_d.apart = blk.alpha_part;
		for (int p = 0; p < 16; p++) begin
			s1_d.mask[p] = col_ok[p % 4] && row_ok[p / 4];
		end
		s1_d.bx = col_q;
		s1_d.by = row_q;
		s1_d.last_block = (col_nx == bx_cnt) && (row_nx == by_cnt);
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			c2[ch] = s1_s1.three ? s1_s1.n2[ch][8:1] : div3(s1_s1.n2[ch]);
			c3[ch] = s1_s1.three ? 8'd0 : div3(s1_s1.n3[ch]);
		end
		push_data.fmt    = s1_s1.fmt;
		push_data.pal[0] = '{r: s1_s1.e0[2], g: s1_s1.e0[1], b: s1_s1.e0[0], a: 8'hFF};
		push_data.pal[1] = '{r: s1_s1.e1[2], g: s1_s1.e1[1], b: s1_s1.e1[0], a: 8'hFF};
		push_data.pal[2] = '{r: c2[2], g: c2[1], b: c2[0], a: 8'hFF};
		push_data.pal[3] = '{r: c3[2], g: c3[1], b: c3[0],
			a: (s1_s1.three ? 8'h00 : 8'hFF)};
		push_data.atab[0] = s1_s1.a0;
		push_data.atab[1] = s1_s1.a1;
		for (int i = 1; i <= 6; i++) begin
			if (s1_s1.agt) begin
				push_data.atab[i+1] = div7(s1_s1.an[i-1]);
			end else if (i <= 4) begin
				push_data.atab[i+1] = div5(s1_s1.an[i-1]);
			end else begin
				push_data.atab[i+1] = (i == 5) ? 8'h00 : 8'hFF;
			end
		end
		push_data.cidx       = s1_s1.cidx;
		push_data.anib       = s1_s1.apart;
		push_data.aidx       = s1_s1.apart[63:16];
		push_data.mask       = s1_s1.mask;
		push_data.bx         = s1_s1.bx;
		push_data.by         = s1_s1.by;
		push_data.last_block = s1_s1.last_block;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_raw_q   <= FMT_BC1;
			width_q     <= DIM_W'(4);
			height_q    <= DIM_W'(4);
			col_q       <= '0;
			row_q       <= '0;
			s1_valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FORMAT: fmt_raw_q <= cfg_data[1:0];
					CFG_WIDTH:  width_q   <= cfg_data;
					CFG_HEIGHT: height_q  <= cfg_data;
					default: ;
				endcase
			end
			if (blk.ready) begin
				s1_valid_s1 <= blk.valid;
			end
			if (acc) begin
				if (col_nx >= bx_cnt) begin
					col_q <= '0;
					if (row_nx >= by_cnt) begin
						row_q <= '0;
					end else begin
						row_q <= row_nx[COUNT_W-1:0];
					end
				end else begin
					col_q <= col_nx[COUNT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_s1 <= s1_d;
		end
	end

endmodule

/* design/bctd_fifo.sv */
// Short queue of decoded block descriptors between front and back end.
module bctd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  bctd_pkg::blk_entry_t push_data,
	input  logic                 pop,
	output bctd_pkg::blk_entry_t pop_data,
	output bctd_pkg::qstat_t     qstat
);
	import bctd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

	blk_entry_t         mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign pop_data    = mem_q[rd_ptr_q];
	assign qstat.full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* design/bctd_back.sv */
// Back end: walks the sixteen pixels of a block and registers each output item.
module bctd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bctd_pkg::qstat_t     qstat,
	input  bctd_pkg::blk_entry_t pop_data,
	output logic                 pop,
	bctd_pixel_if.source         pix
);
	import bctd_pkg::*;

	blk_entry_t          cur_q;
	logic                cur_valid_q;
	logic [3:0]          pidx_q;
	logic                pix_valid_q;
	logic [COORD_W-1:0]  pixel_x_q;
	logic [COORD_W-1:0]  pixel_y_q;
	rgba_t               color_q;
	logic                block_done_q;
	logic                image_done_q;

	logic                emit;
	logic                out_free;
	logic                step;
	logic                last_step;
	logic                block_end;
	rgba_t               texel;
	logic [3:0]          nib;

	always_comb begin
		emit      = cur_valid_q && cur_q.mask[pidx_q];
		out_free  = !pix_valid_q || pix.ready;
		step      = cur_valid_q && (!cur_q.mask[pidx_q] || out_free);
		last_step = step && (pidx_q == 4'd15);
		pop       = !qstat.empty && (!cur_valid_q || last_step);
		block_end = (cur_q.mask >> pidx_q) == 16'd1;
		texel     = cur_q.pal[cur_q.cidx[pidx_q]];
		nib       = cur_q.anib[pidx_q];
		case (cur_q.fmt)
			FMT_BC2: texel.a = {nib, nib};
			FMT_BC3: texel.a = cur_q.atab[cur_q.aidx[pidx_q]];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			pidx_q      <= '0;
			pix_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				pidx_q      <= '0;
			end else if (step) begin
				pidx_q <= pidx_q + 4'd1;
				if (last_step) begin
					cur_valid_q <= 1'b0;
				end
			end
			if (out_free) begin
				pix_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_data;
		end
		if (emit && out_free) begin
			pixel_x_q    <= {cur_q.bx, pidx_q[1:0]};
			pixel_y_q    <= {cur_q.by, pidx_q[3:2]};
			color_q      <= texel;
			block_done_q <= block_end;
			image_done_q <= block_end && cur_q.last_block;
		end
	end

	assign pix.valid      = pix_valid_q;
	assign pix.pixel_x    = pixel_x_q;
	assign pix.pixel_y    = pixel_y_q;
	assign pix.red        = color_q.r;
	assign pix.green      = color_q.g;
	assign pix.blue       = color_q.b;
	assign pix.alpha      = color_q.a;
	assign pix.block_done = block_done_q;
	assign pix.image_done = image_done_q;

endmodule
